>>> rtl/sdm_pkg.sv
// Package for the sign-driven drive-mode controller.
// Holds mode, sign, timer-slot, request and register codes plus register reset values.
// No dependencies.
`default_nettype none

package sdm_pkg;

	localparam int MODE_W = 4;
	localparam int KIND_W = 3;
	localparam int REQ_W = 2;
	localparam int DIST_W = 16;
	localparam int THR_W = 16;
	localparam int NEAR_W = 15;
	localparam int SEC_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int N_TIMERS = 7;
	localparam int SLOT_W = 3;

	// drive modes
	localparam logic [MODE_W-1:0] M_DRIVE   = 4'd0;
	localparam logic [MODE_W-1:0] M_CW_BEF  = 4'd1;
	localparam logic [MODE_W-1:0] M_CW_NOW  = 4'd2;
	localparam logic [MODE_W-1:0] M_RO_BEF  = 4'd3;
	localparam logic [MODE_W-1:0] M_RO_NOW  = 4'd4;
	localparam logic [MODE_W-1:0] M_RED_BEF = 4'd5;
	localparam logic [MODE_W-1:0] M_RED_NOW = 4'd6;
	localparam logic [MODE_W-1:0] M_YEL_BEF = 4'd7;
	localparam logic [MODE_W-1:0] M_YEL_NOW = 4'd8;
	localparam logic [MODE_W-1:0] M_GRN_BEF = 4'd9;
	localparam logic [MODE_W-1:0] M_GRN_NOW = 4'd10;
	localparam logic [MODE_W-1:0] M_LAST    = M_GRN_NOW;

	// sign kinds
	localparam logic [KIND_W-1:0] K_NONE = 3'd0;
	localparam logic [KIND_W-1:0] K_CW   = 3'd1;
	localparam logic [KIND_W-1:0] K_RO   = 3'd2;
	localparam logic [KIND_W-1:0] K_RED  = 3'd3;
	localparam logic [KIND_W-1:0] K_YEL  = 3'd4;
	localparam logic [KIND_W-1:0] K_GRN  = 3'd5;

	// timer slots
	localparam logic [SLOT_W-1:0] T_CW_HOLD = 3'd0;
	localparam logic [SLOT_W-1:0] T_CW_LOST = 3'd1;
	localparam logic [SLOT_W-1:0] T_RO_HOLD = 3'd2;
	localparam logic [SLOT_W-1:0] T_RO_LOST = 3'd3;
	localparam logic [SLOT_W-1:0] T_RED     = 3'd4;
	localparam logic [SLOT_W-1:0] T_YEL     = 3'd5;
	localparam logic [SLOT_W-1:0] T_GRN     = 3'd6;

	// request types
	localparam logic [REQ_W-1:0] REQ_SIGN  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_TICK  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_EMPTY = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_THROTTLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CROSSWALK_NEAR  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROTARY_NEAR     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIGHT_NEAR      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CROSSWALK_HOLD  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROTARY_HOLD     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LOST_SIGN       = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_START_MODE      = 3'd7;

	// register reset values
	localparam logic [THR_W-1:0]  RST_NORMAL_THROTTLE = 16'd0;
	localparam logic [NEAR_W-1:0] RST_CROSSWALK_NEAR  = 15'd800;
	localparam logic [NEAR_W-1:0] RST_ROTARY_NEAR     = 15'd480;
	localparam logic [NEAR_W-1:0] RST_LIGHT_NEAR      = 15'd640;
	localparam logic [SEC_W-1:0]  RST_CROSSWALK_HOLD  = 8'd6;
	localparam logic [SEC_W-1:0]  RST_ROTARY_HOLD     = 8'd9;
	localparam logic [SEC_W-1:0]  RST_LOST_SIGN       = 8'd5;
	localparam logic [MODE_W-1:0] RST_START_MODE      = M_DRIVE;

	localparam logic [SEC_W-1:0] SEC_MAX = {SEC_W{1'b1}};

	function automatic logic is_light(input logic [KIND_W-1:0] k);
		return (k == K_RED) || (k == K_YEL) || (k == K_GRN);
	endfunction

	function automatic logic [MODE_W-1:0] light_before(input logic [KIND_W-1:0] k);
		return (k == K_RED) ? M_RED_BEF : ((k == K_YEL) ? M_YEL_BEF : M_GRN_BEF);
	endfunction

	function automatic logic [MODE_W-1:0] light_now(input logic [KIND_W-1:0] k);
		return (k == K_RED) ? M_RED_NOW : ((k == K_YEL) ? M_YEL_NOW : M_GRN_NOW);
	endfunction

endpackage

`default_nettype wire

>>> rtl/sign_driven_drive_mode_fsm.sv
// Sign-driven drive-mode controller: mode/throttle state machine with timers.
// Depends on sdm_pkg.
//
// channel | direction | handshake             | payload
// --------+-----------+-----------------------+-----------------------------------
// in      | in        | in_valid / in_ready   | req_type, sign_kind, sign_range
// out     | out       | out_valid / out_ready | drive_mode, throttle_out
// cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled.
// An input register holds the item, one pass of logic updates mode, throttle and
// timers, and the state registers themselves form the result register.
// While the result is stalled one more item waits in the input register.
// Reset restores registers to defaults and the mode to driving; cfg_ready is always high.
`default_nettype none

module sign_driven_drive_mode_fsm
	import sdm_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [REQ_W-1:0]         req_type,
	input  wire logic [KIND_W-1:0]        sign_kind,
	input  wire logic signed [DIST_W-1:0] sign_range,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [MODE_W-1:0]             drive_mode,
	output logic [THR_W-1:0]              throttle_out,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_DATA_W-1:0]    cfg_data
);

	// configuration
	logic [THR_W-1:0]  normal_throttle_q;
	logic [NEAR_W-1:0] crosswalk_near_q, rotary_near_q, light_near_q;
	logic [SEC_W-1:0]  crosswalk_hold_q, rotary_hold_q, lost_sign_q;

	// input stage
	logic                     valid_s1;
	logic [REQ_W-1:0]         req_s1;
	logic [KIND_W-1:0]        kind_s1;
	logic signed [DIST_W-1:0] dist_s1;

	// state, also the result
	logic [MODE_W-1:0]           mode_q;
	logic [THR_W-1:0]            throttle_q;
	logic [N_TIMERS-1:0]         armed_q;
	logic [N_TIMERS-1:0][SEC_W-1:0] secs_q;
	logic                        out_valid_q;

	logic                        advance;
	logic [MODE_W-1:0]           mode_n;
	logic [THR_W-1:0]            thr_n;
	logic [N_TIMERS-1:0]         armed_n;
	logic [N_TIMERS-1:0][SEC_W-1:0] secs_n;

	assign cfg_ready    = 1'b1;
	assign advance      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready     = !valid_s1 || advance;
	assign out_valid    = out_valid_q;
	assign drive_mode   = mode_q;
	assign throttle_out = throttle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_throttle_q <= RST_NORMAL_THROTTLE;
			crosswalk_near_q  <= RST_CROSSWALK_NEAR;
			rotary_near_q     <= RST_ROTARY_NEAR;
			light_near_q      <= RST_LIGHT_NEAR;
			crosswalk_hold_q  <= RST_CROSSWALK_HOLD;
			rotary_hold_q     <= RST_ROTARY_HOLD;
			lost_sign_q       <= RST_LOST_SIGN;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_NORMAL_THROTTLE: normal_throttle_q <= cfg_data;
				REG_CROSSWALK_NEAR:  crosswalk_near_q  <= cfg_data[NEAR_W-1:0];
				REG_ROTARY_NEAR:     rotary_near_q     <= cfg_data[NEAR_W-1:0];
				REG_LIGHT_NEAR:      light_near_q      <= cfg_data[NEAR_W-1:0];
				REG_CROSSWALK_HOLD:  crosswalk_hold_q  <= cfg_data[SEC_W-1:0];
				REG_ROTARY_HOLD:     rotary_hold_q     <= cfg_data[SEC_W-1:0];
				REG_LOST_SIGN:       lost_sign_q       <= cfg_data[SEC_W-1:0];
				// start mode only matters at reset, which restores its default
				REG_START_MODE: ;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1  <= req_type;
			kind_s1 <= sign_kind;
			dist_s1 <= sign_range;
		end
	end

	always_comb begin
		logic                  appr, hld, seen;
		logic [KIND_W-1:0]     tgt, own;
		logic [SLOT_W-1:0]     slot;
		logic [SEC_W-1:0]      limit;
		logic [THR_W-1:0]      first_thr;
		logic                  pos;
		logic signed [DIST_W-1:0] cw_thr, ro_thr, li_thr;

		mode_n    = mode_q;
		thr_n     = throttle_q;
		armed_n   = armed_q;
		secs_n    = secs_q;
		appr      = 1'b0;
		hld       = 1'b0;
		seen      = 1'b1;
		tgt       = K_NONE;
		own       = K_NONE;
		slot      = T_CW_HOLD;
		limit     = '0;
		first_thr = normal_throttle_q;
		pos       = dist_s1 > 0;
		cw_thr    = $signed({1'b0, crosswalk_near_q});
		ro_thr    = $signed({1'b0, rotary_near_q});
		li_thr    = $signed({1'b0, light_near_q});

		case (req_s1)
			REQ_SIGN: begin
				// move on the sign seen
				case (mode_q)
					M_DRIVE: begin
						if (kind_s1 == K_CW) mode_n = M_CW_BEF;
						else if (kind_s1 == K_RO) mode_n = M_RO_BEF;
						else if (is_light(kind_s1)) mode_n = light_before(kind_s1);
					end
					M_CW_BEF: begin
						if (kind_s1 == K_CW && pos && dist_s1 < cw_thr) mode_n = M_CW_NOW;
					end
					M_CW_NOW, M_RO_NOW: ;
					M_RO_BEF: begin
						if (kind_s1 == K_RO && pos && dist_s1 < ro_thr) mode_n = M_RO_NOW;
					end
					M_RED_BEF, M_YEL_BEF, M_GRN_BEF: begin
						own = (mode_q == M_RED_BEF) ? K_RED :
							((mode_q == M_YEL_BEF) ? K_YEL : K_GRN);
						if (is_light(kind_s1) && kind_s1 != own) mode_n = light_before(kind_s1);
						else if (kind_s1 == K_NONE) mode_n = M_DRIVE;
						else if (kind_s1 == own && pos && dist_s1 < li_thr)
							mode_n = light_now(own);
					end
					M_RED_NOW, M_YEL_NOW, M_GRN_NOW: begin
						own = (mode_q == M_RED_NOW) ? K_RED :
							((mode_q == M_YEL_NOW) ? K_YEL : K_GRN);
						if (is_light(kind_s1) && kind_s1 != own) mode_n = light_now(kind_s1);
						else if (kind_s1 == K_NONE) mode_n = M_DRIVE;
					end
					default: mode_n = M_DRIVE;
				endcase

				// action of the mode landed in
				case (mode_n)
					M_CW_BEF:  begin appr = 1'b1; tgt = K_CW;  slot = T_CW_LOST; end
					M_RO_BEF:  begin appr = 1'b1; tgt = K_RO;  slot = T_RO_LOST; end
					M_RED_BEF: begin appr = 1'b1; tgt = K_RED; slot = T_RED; end
					M_YEL_BEF: begin appr = 1'b1; tgt = K_YEL; slot = T_YEL; end
					M_GRN_BEF: begin appr = 1'b1; tgt = K_GRN; slot = T_GRN; end
					M_CW_NOW: begin
						hld = 1'b1; slot = T_CW_HOLD; limit = crosswalk_hold_q;
						first_thr = normal_throttle_q >> 1;
					end
					M_RO_NOW: begin
						hld = 1'b1; slot = T_RO_HOLD; limit = rotary_hold_q;
					end
					M_RED_NOW, M_YEL_NOW: thr_n = '0;
					default: thr_n = normal_throttle_q;
				endcase

				if (appr) begin
					if (kind_s1 == tgt) begin
						armed_n[slot] = 1'b0;
					end else if (!armed_q[slot]) begin
						armed_n[slot] = 1'b1;
						secs_n[slot]  = '0;
					end else if (secs_q[slot] > lost_sign_q) begin
						armed_n[slot] = 1'b0;
						seen = 1'b0;
					end
					if (!seen) mode_n = M_DRIVE;
					thr_n = normal_throttle_q;
				end

				if (hld) begin
					if (!armed_q[slot]) begin
						armed_n[slot] = 1'b1;
						secs_n[slot]  = '0;
						thr_n = first_thr;
					end else if (secs_q[slot] >= limit) begin
						// hold expired: back to driving, throttle kept
						mode_n = M_DRIVE;
						armed_n[slot] = 1'b0;
					end
				end
			end
			REQ_TICK: begin
				for (int i = 0; i < N_TIMERS; i++) begin
					if (armed_q[i] && secs_q[i] != SEC_MAX) secs_n[i] = secs_q[i] + 1'b1;
				end
			end
			REQ_EMPTY: thr_n = normal_throttle_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= RST_START_MODE;
			throttle_q  <= '0;
			armed_q     <= '0;
			secs_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				mode_q     <= mode_n;
				throttle_q <= thr_n;
				armed_q    <= armed_n;
				secs_q     <= secs_n;
			end
			if (advance) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

>>> rtl/sdm_checker.sv
// Port-level checks for the sign-driven drive-mode controller, bound to the top level.
// Depends on sdm_pkg and sign_driven_drive_mode_fsm.
`default_nettype none

module sdm_checker
	import sdm_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [MODE_W-1:0] drive_mode,
	input wire logic [THR_W-1:0]  throttle_out
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive_mode) && $stable(throttle_out))
		else $error("result changed while stalled");

	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> drive_mode <= M_LAST)
		else $error("drive mode out of range");

	// every transfer in shows a valid result once it has passed the input and state registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##2 out_valid)
		else $error("result missing after input transfer");

	// full pipe stays closed while the output stays stalled
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready && !in_ready) ##1 !out_ready |-> !in_ready)
		else $error("input accepted into a full pipe");

endmodule

bind sign_driven_drive_mode_fsm sdm_checker u_sdm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.drive_mode   (drive_mode),
	.throttle_out (throttle_out)
);

`default_nettype wire

>>> sim/tb_sign_driven_drive_mode_fsm.sv
// Testbench for sign_driven_drive_mode_fsm: directed and random sign, tick and
// empty-list transfers, checked against a scoreboard that tracks mode, throttle and timers.
// Depends on sdm_pkg and the sign_driven_drive_mode_fsm RTL.
`default_nettype none

module tb_sign_driven_drive_mode_fsm;
	import sdm_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam logic [KIND_W-1:0] K_OTHER  = 3'd6;
	localparam logic [KIND_W-1:0] K_UNUSED = 3'd7;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0] md;
		logic [THR_W-1:0]  thr;
	} drive_result_t;

	class drive_mode_scoreboard;
		logic [THR_W-1:0]  normal_thr;
		logic [NEAR_W-1:0] cw_near, ro_near, lt_near;
		logic [SEC_W-1:0]  cw_hold, ro_hold, lost_limit;
		logic [MODE_W-1:0] start_md;
		logic [MODE_W-1:0] mode;
		logic [THR_W-1:0]  throttle;
		bit                armed [N_TIMERS];
		logic [SEC_W-1:0]  seconds [N_TIMERS];
		drive_result_t     expected_q [$];
		int                errors;

		function new();
			normal_thr = RST_NORMAL_THROTTLE;
			cw_near = RST_CROSSWALK_NEAR;
			ro_near = RST_ROTARY_NEAR;
			lt_near = RST_LIGHT_NEAR;
			cw_hold = RST_CROSSWALK_HOLD;
			ro_hold = RST_ROTARY_HOLD;
			lost_limit = RST_LOST_SIGN;
			start_md = RST_START_MODE;
			mode = RST_START_MODE;
			throttle = '0;
			for (int i = 0; i < N_TIMERS; i++) begin
				armed[i] = 1'b0;
				seconds[i] = '0;
			end
			errors = 0;
		endfunction

		// start_mode only matters at reset, which happens once at time zero
		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_NORMAL_THROTTLE: normal_thr = data;
				REG_CROSSWALK_NEAR:  cw_near = data[NEAR_W-1:0];
				REG_ROTARY_NEAR:     ro_near = data[NEAR_W-1:0];
				REG_LIGHT_NEAR:      lt_near = data[NEAR_W-1:0];
				REG_CROSSWALK_HOLD:  cw_hold = data[SEC_W-1:0];
				REG_ROTARY_HOLD:     ro_hold = data[SEC_W-1:0];
				REG_LOST_SIGN:       lost_limit = data[SEC_W-1:0];
				REG_START_MODE:      start_md = data[MODE_W-1:0];
				default: ;
			endcase
		endfunction

		function void arm_timer(int slot);
			armed[slot] = 1'b1;
			seconds[slot] = '0;
		endfunction

		function bit sign_still_seen(logic [KIND_W-1:0] kind, logic [KIND_W-1:0] target,
				int slot);
			if (kind == target) begin
				armed[slot] = 1'b0;
				return 1'b1;
			end
			if (!armed[slot]) begin
				arm_timer(slot);
			end else if (seconds[slot] > lost_limit) begin
				armed[slot] = 1'b0;
				return 1'b0;
			end
			return 1'b1;
		endfunction

		function bit is_near(logic signed [DIST_W-1:0] span, logic [NEAR_W-1:0] thr_q);
			int d;
			int t;
			d = int'(span);
			t = int'(thr_q);
			return (d > 0) && (d < t);
		endfunction

		function void approach(logic [KIND_W-1:0] kind, logic [KIND_W-1:0] target, int slot);
			if (!sign_still_seen(kind, target, slot))
				mode = M_DRIVE;
			throttle = normal_thr;
		endfunction

		function void hold_mode(int slot, logic [SEC_W-1:0] limit, logic [THR_W-1:0] first_thr);
			if (!armed[slot]) begin
				arm_timer(slot);
				throttle = first_thr;
			end else if (seconds[slot] >= limit) begin
				mode = M_DRIVE;
				armed[slot] = 1'b0;
			end
		endfunction

		function logic [MODE_W-1:0] light_mode(logic [KIND_W-1:0] kind, bit active);
			case (kind)
				K_RED:   return active ? M_RED_NOW : M_RED_BEF;
				K_YEL:   return active ? M_YEL_NOW : M_YEL_BEF;
				default: return active ? M_GRN_NOW : M_GRN_BEF;
			endcase
		endfunction

		function logic [KIND_W-1:0] light_of(logic [MODE_W-1:0] m);
			if (m == M_RED_BEF || m == M_RED_NOW)
				return K_RED;
			if (m == M_YEL_BEF || m == M_YEL_NOW)
				return K_YEL;
			return K_GRN;
		endfunction

		function void observe(logic [KIND_W-1:0] kind, logic signed [DIST_W-1:0] span);
			logic [KIND_W-1:0] own;
			bit                lit;
			lit = (kind >= K_RED) && (kind <= K_GRN);
			own = light_of(mode);
			case (mode)
				M_DRIVE: begin
					if (kind == K_CW)
						mode = M_CW_BEF;
					else if (kind == K_RO)
						mode = M_RO_BEF;
					else if (lit)
						mode = light_mode(kind, 1'b0);
				end
				M_CW_BEF: begin
					if (kind == K_CW && is_near(span, cw_near))
						mode = M_CW_NOW;
				end
				M_CW_NOW, M_RO_NOW: ;
				M_RO_BEF: begin
					if (kind == K_RO && is_near(span, ro_near))
						mode = M_RO_NOW;
				end
				M_RED_BEF, M_YEL_BEF, M_GRN_BEF: begin
					if (lit && kind != own)
						mode = light_mode(kind, 1'b0);
					else if (kind == K_NONE)
						mode = M_DRIVE;
					else if (kind == own && is_near(span, lt_near))
						mode = light_mode(own, 1'b1);
				end
				M_RED_NOW, M_YEL_NOW, M_GRN_NOW: begin
					if (lit && kind != own)
						mode = light_mode(kind, 1'b1);
					else if (kind == K_NONE)
						mode = M_DRIVE;
				end
				default: mode = M_DRIVE;
			endcase

			case (mode)
				M_CW_BEF:  approach(kind, K_CW, T_CW_LOST);
				M_CW_NOW:  hold_mode(T_CW_HOLD, cw_hold, normal_thr >> 1);
				M_RO_BEF:  approach(kind, K_RO, T_RO_LOST);
				M_RO_NOW:  hold_mode(T_RO_HOLD, ro_hold, normal_thr);
				M_RED_BEF: approach(kind, K_RED, T_RED);
				M_YEL_BEF: approach(kind, K_YEL, T_YEL);
				M_GRN_BEF: approach(kind, K_GRN, T_GRN);
				M_RED_NOW, M_YEL_NOW: throttle = '0;
				default: throttle = normal_thr;
			endcase
		endfunction

		function void note_item(logic [REQ_W-1:0] req, logic [KIND_W-1:0] kind,
				logic signed [DIST_W-1:0] span);
			drive_result_t r;
			case (req)
				REQ_SIGN: observe(kind, span);
				REQ_TICK: begin
					for (int i = 0; i < N_TIMERS; i++)
						if (armed[i] && seconds[i] != SEC_MAX)
							seconds[i]++;
				end
				REQ_EMPTY: throttle = normal_thr;
				default: ;
			endcase
			r.md = mode;
			r.thr = throttle;
			expected_q.push_back(r);
		endfunction

		function void check_result(logic [MODE_W-1:0] md, logic [THR_W-1:0] thr);
			drive_result_t e;
			if (expected_q.size() == 0) begin
				$error("unexpected result: drive_mode=%0d throttle_out=%h", md, thr);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (md !== e.md) begin
				$error("drive_mode mismatch: expected %0d, actual %0d", e.md, md);
				errors++;
			end
			if (thr !== e.thr) begin
				$error("throttle_out mismatch: expected %h, actual %h", e.thr, thr);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [REQ_W-1:0]         req_type = '0;
	logic [KIND_W-1:0]        sign_kind = '0;
	logic signed [DIST_W-1:0] sign_range = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [MODE_W-1:0]        drive_mode;
	logic [THR_W-1:0]         throttle_out;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_DATA_W-1:0]    cfg_data = '0;

	drive_mode_scoreboard sb;
	int idle_pct = 0;
	int stall_pct = 0;
	int cycle_count = 0;

	sign_driven_drive_mode_fsm DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.sign_kind(sign_kind),
		.sign_range(sign_range),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.drive_mode(drive_mode),
		.throttle_out(throttle_out),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("** sign_driven_drive_mode_fsm: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready)
			sb.check_result(drive_mode, throttle_out);
	end

	function automatic logic [15:0] rand16(int lo, int hi);
		return 16'($urandom_range(hi, lo));
	endfunction

	// hold valid and payload until the transfer, then note it
	task automatic send_item(logic [REQ_W-1:0] req, logic [KIND_W-1:0] kind,
			logic signed [DIST_W-1:0] span);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		sign_kind <= kind;
		sign_range <= span;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.note_item(req, kind, span);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.write_reg(idx, data);
	endtask

	task automatic configure(logic [15:0] thr, logic [15:0] cwn, logic [15:0] ron,
			logic [15:0] ltn, logic [15:0] cwh, logic [15:0] roh, logic [15:0] lost,
			logic [15:0] start);
		write_reg(REG_NORMAL_THROTTLE, thr);
		write_reg(REG_CROSSWALK_NEAR, cwn);
		write_reg(REG_ROTARY_NEAR, ron);
		write_reg(REG_LIGHT_NEAR, ltn);
		write_reg(REG_CROSSWALK_HOLD, cwh);
		write_reg(REG_ROTARY_HOLD, roh);
		write_reg(REG_LOST_SIGN, lost);
		write_reg(REG_START_MODE, start);
		cfg_valid <= 1'b0;
	endtask

	// drop valid, wait for every result, then let the pipeline settle
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic signed [DIST_W-1:0] pick_distance(logic [KIND_W-1:0] kind);
		int thr_q;
		int v;
		if (kind == K_RO)
			thr_q = int'(sb.ro_near);
		else if (kind >= K_RED && kind <= K_GRN)
			thr_q = int'(sb.lt_near);
		else
			thr_q = int'(sb.cw_near);
		case ($urandom_range(9))
			0, 1, 2, 3: v = (thr_q > 1) ? $urandom_range(thr_q - 1, 1) : 1;
			4: v = 0;
			5: v = thr_q;
			6: v = thr_q - 1;
			7: v = 1;
			8: v = -int'($urandom_range(32768, 1));
			default: v = $urandom_range(65535);
		endcase
		return v[DIST_W-1:0];
	endfunction

	// sequences around one focus sign; lost sequences drop the sign after it appears
	task automatic run_random(int count);
		int                done;
		int                seq_len;
		int                pick;
		bit                lost_seq;
		logic [KIND_W-1:0] focus;
		logic [KIND_W-1:0] kind;
		done = 0;
		while (done < count) begin
			focus = KIND_W'($urandom_range(5, 1));
			lost_seq = ($urandom_range(3) == 0);
			seq_len = $urandom_range(30, 8);
			for (int i = 0; i < seq_len && done < count; i++) begin
				pick = $urandom_range(99);
				if (pick < 40) begin
					kind = (lost_seq && i > 1) ? ($urandom_range(1) ? K_OTHER : K_UNUSED)
						: focus;
					send_item(REQ_SIGN, kind, pick_distance(kind));
				end else if (pick < 65) begin
					send_item(REQ_TICK, KIND_W'($urandom_range(7)), rand16(0, 65535));
				end else if (pick < 80) begin
					kind = KIND_W'($urandom_range(7));
					send_item(REQ_SIGN, kind, pick_distance(kind));
				end else if (pick < 88) begin
					send_item(REQ_EMPTY, KIND_W'($urandom_range(7)), rand16(0, 65535));
				end else begin
					send_item(REQ_W'($urandom_range(3)), KIND_W'($urandom_range(7)),
						rand16(0, 65535));
				end
				done++;
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed walk: odd throttle shows the rounded-down half at the crosswalk
		configure(16'hFFFF, 16'd800, 16'd480, 16'd640, 16'd1, 16'd1, 16'd1, 16'd15);
		send_item(REQ_UNUSED, K_UNUSED, 16'sh7FFF);
		send_item(REQ_EMPTY, K_NONE, 16'sd0);
		send_item(REQ_SIGN, K_UNUSED, 16'sh8000);
		send_item(REQ_SIGN, K_CW, 16'sd800);
		send_item(REQ_SIGN, K_CW, 16'sd799);
		send_item(REQ_TICK, K_NONE, 16'sd0);
		send_item(REQ_TICK, K_NONE, 16'sd0);
		send_item(REQ_SIGN, K_NONE, 16'sd0);
		send_item(REQ_SIGN, K_RO, -16'sd1);
		send_item(REQ_SIGN, K_RO, 16'sd1);
		send_item(REQ_TICK, K_NONE, 16'sd0);
		send_item(REQ_SIGN, K_OTHER, 16'sd0);
		send_item(REQ_SIGN, K_RED, 16'sd32767);
		send_item(REQ_SIGN, K_OTHER, 16'sd3);
		send_item(REQ_TICK, K_NONE, 16'sd0);
		send_item(REQ_TICK, K_NONE, 16'sd0);
		send_item(REQ_SIGN, K_UNUSED, 16'sd3);
		send_item(REQ_SIGN, K_YEL, 16'sd639);
		send_item(REQ_SIGN, K_GRN, 16'sd639);
		send_item(REQ_SIGN, K_GRN, 16'sd639);
		send_item(REQ_SIGN, K_RED, 16'sd1);
		send_item(REQ_SIGN, K_YEL, 16'sd1);
		send_item(REQ_SIGN, K_NONE, 16'sd0);
		// crosswalk approach must watch for the crosswalk sign, not the roundabout one
		send_item(REQ_SIGN, K_CW, 16'sd5000);
		send_item(REQ_SIGN, K_RO, 16'sd10);
		send_item(REQ_TICK, K_NONE, 16'sd0);
		send_item(REQ_TICK, K_NONE, 16'sd0);
		send_item(REQ_SIGN, K_RO, 16'sd10);
		drain();

		configure(rand16(0, 65535), 16'd800, 16'd480, 16'd640, 16'd3, 16'd4, 16'd2,
			16'd0);
		run_random(150);
		drain();

		idle_pct = 75;
		configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd10);
		run_random(150);
		drain();

		// top of every range; upper data bits beyond each narrower register width are set too
		idle_pct = 0;
		stall_pct = 75;
		configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF);
		send_item(REQ_SIGN, K_NONE, 16'sd0);
		send_item(REQ_SIGN, K_CW, 16'sd1);
		send_item(REQ_SIGN, K_CW, 16'sd1);
		send_item(REQ_SIGN, K_OTHER, 16'sd1);
		repeat (260) send_item(REQ_TICK, K_NONE, 16'sd0);
		send_item(REQ_SIGN, K_OTHER, 16'sd1);
		send_item(REQ_SIGN, K_NONE, 16'sd0);
		run_random(150);
		drain();

		idle_pct = 37;
		stall_pct = 37;
		configure(rand16(0, 65535), rand16(1, 2000), rand16(1, 2000), rand16(1, 2000),
			rand16(0, 8), rand16(0, 8), rand16(0, 6), rand16(0, 15));
		run_random(150);
		drain();

		idle_pct = 0;
		stall_pct = 0;
		configure(rand16(0, 65535), rand16(1, 2000), rand16(1, 2000), rand16(1, 2000),
			rand16(0, 8), rand16(0, 8), rand16(0, 6), rand16(0, 15));
		run_random(150);
		drain();

		idle_pct = 37;
		stall_pct = 37;
		configure(rand16(0, 65535), rand16(0, 32767), rand16(0, 32767), rand16(0, 32767),
			rand16(0, 8), rand16(0, 8), rand16(0, 6), rand16(0, 15));
		run_random(150);
		drain();

		if (sb.errors == 0 && sb.pending() == 0)
			$display("** sign_driven_drive_mode_fsm: PASSED **");
		else
			$display("** sign_driven_drive_mode_fsm: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire

>>> filelist.f
rtl/sdm_pkg.sv
rtl/sign_driven_drive_mode_fsm.sv
rtl/sdm_checker.sv
sim/tb_sign_driven_drive_mode_fsm.sv
